/* sv/chw_pkg.sv */
// ----------------------------------------------------------------------------
// chw_pkg
// Types and constants shared by the chip health watchdog modules.
// ----------------------------------------------------------------------------
`default_nettype none

package chw_pkg;

   // command codes of an input item
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_REPORT = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;

   // nonce report outcomes
   localparam logic [1:0] OUTC_VALID = 2'd0;
   localparam logic [1:0] OUTC_HWERR = 2'd1;
   localparam logic [1:0] OUTC_DUPE  = 2'd2;

   // watchdog action codes
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_TIMEOUT = 2'd1;
   localparam logic [1:0] ACT_ERRORS  = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CHIP_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_ONLY    = 3'd4;

   // grace added to the stamp on start and on an idle tick
   localparam logic [31:0] START_GRACE  = 32'd10;
   localparam logic [31:0] IDLE_GRACE   = 32'd20;
   localparam logic [15:0] ERR_RUN_MAX  = 16'hFFFF;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 168;

   typedef struct packed {
      logic [4:0]  chip_count;
      logic [15:0] enable_mask;
      logic [15:0] timeout_seconds;
      logic [15:0] error_limit;
      logic        log_only;
   } cfg_type;

   // one row of per-chip state held in the ram
   typedef struct packed {
      logic [31:0] last_active;
      logic [15:0] error_run;
      logic [31:0] valid_count;
      logic [31:0] dupe_count;
      logic [31:0] timeout_actions;
      logic [31:0] error_actions;
   } row_type;

   typedef struct packed {
      logic latch;
      logic rd;
      logic upd;
      logic use_chip;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       idle;
      logic       chip_ok;
      logic       at_end;
      logic       en_here;
      logic       hit;
   } dp_status_type;

endpackage

`default_nettype wire

/* sv/chw_ram.sv */
// ----------------------------------------------------------------------------
// chw_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module chw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/chw_ctrl.sv */
// ----------------------------------------------------------------------------
// chw_ctrl
// Sequencer: walks the chips for start and tick items, drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module chw_ctrl #(
   parameter int unsigned MAX_CHIPS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire chw_pkg::dp_status_type               status,
   output chw_pkg::dp_cmd_type                       cmd,
   output logic [$clog2(MAX_CHIPS + 1)-1:0]          idx
);

   localparam int unsigned CW = $clog2(MAX_CHIPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_UPDATE,
      ST_STAT_RD,
      ST_STAT
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            busy_tick;

   assign busy_tick = (status.op == chw_pkg::OP_TICK) && !status.idle;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               idx_in    = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            case (status.op)
               chw_pkg::OP_START, chw_pkg::OP_TICK: begin
                  if (status.at_end) begin
                     state_in = ST_STAT_RD;
                  end else if (busy_tick && !status.en_here) begin
                     idx_in = CW'(idx_ff + 1'b1);
                  end else begin
                     state_in = ST_READ;
                  end
               end
               chw_pkg::OP_REPORT: begin
                  state_in = status.chip_ok ? ST_READ : ST_STAT_RD;
               end
               default: begin
                  state_in = ST_STAT_RD;
               end
            endcase
         end
         ST_READ: begin
            cmd.rd       = 1'b1;
            cmd.use_chip = (status.op == chw_pkg::OP_REPORT);
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd      = 1'b1;
            cmd.use_chip = (status.op == chw_pkg::OP_REPORT);
            if ((status.op == chw_pkg::OP_REPORT) || (busy_tick && status.hit)) begin
               state_in = ST_STAT_RD;
            end else begin
               idx_in   = CW'(idx_ff + 1'b1);
               state_in = ST_WALK;
            end
         end
         ST_STAT_RD: begin
            cmd.rd       = 1'b1;
            cmd.use_chip = 1'b1;
            state_in     = ST_STAT;
         end
         ST_STAT: begin
            // the read data holds until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign idx        = idx_ff;

endmodule

`default_nettype wire

/* sv/chw_dp.sv */
// ----------------------------------------------------------------------------
// chw_dp
// Datapath: item latch, per-chip state ram, row update, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chw_dp #(
   parameter int unsigned MAX_CHIPS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire chw_pkg::cfg_type                cfg,
   input  wire logic [1:0]                      in_cmd,
   input  wire logic [31:0]                     in_now,
   input  wire logic [3:0]                      in_chip,
   input  wire logic [1:0]                      in_outcome,
   input  wire logic                            in_idle_pool,
   input  wire chw_pkg::dp_cmd_type             cmd,
   input  wire logic [$clog2(MAX_CHIPS + 1)-1:0] idx,
   output chw_pkg::dp_status_type               status,
   output logic [1:0]                           out_action,
   output logic                                 out_reset_sent,
   output logic [3:0]                           out_action_chip,
   output logic [31:0]                          out_total_resets,
   output logic [31:0]                          out_valid_count,
   output logic [31:0]                          out_dupe_count,
   output logic [31:0]                          out_timeout_resets,
   output logic [31:0]                          out_error_resets
);

   localparam int unsigned CW = $clog2(MAX_CHIPS + 1);
   localparam int unsigned AW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam int unsigned RW = $bits(chw_pkg::row_type);

   // latched item
   logic [1:0]  op_ff;
   logic [31:0] now_ff;
   logic [3:0]  chip_ff;
   logic [1:0]  outcome_ff;
   logic        idle_ff;

   logic [MAX_CHIPS-1:0] row_valid_ff;
   logic [MAX_CHIPS-1:0] stamped_ff;
   logic [MAX_CHIPS-1:0] enabled_ff;
   logic                 rd_valid_ff;

   logic [1:0]  action_ff;
   logic        sent_ff;
   logic [3:0]  achip_ff;
   logic [31:0] total_ff;

   logic [1:0]  out_action_ff;
   logic        out_sent_ff;
   logic [3:0]  out_achip_ff;
   logic [31:0] out_total_ff;
   logic [31:0] out_valid_ff;
   logic [31:0] out_dupe_ff;
   logic [31:0] out_tout_ff;
   logic [31:0] out_err_ff;

   logic [CW-1:0]    chips_n;
   logic             chip_ok;
   logic [AW-1:0]    addr;
   logic [RW-1:0]    ram_q;
   chw_pkg::row_type old_row;
   chw_pkg::row_type new_row;
   logic             stamp_set;
   logic [31:0]      since;
   logic             timed_out;
   logic             too_many;
   logic             hit;
   logic             busy_tick;
   logic             en_bit;

   assign chips_n   = (32'(cfg.chip_count) > MAX_CHIPS) ? CW'(MAX_CHIPS)
                                                          : CW'(cfg.chip_count);
   assign chip_ok   = (32'(chip_ff) < MAX_CHIPS);
   assign addr      = cmd.use_chip ? AW'(chip_ff) : AW'(idx);
   assign busy_tick = (op_ff == chw_pkg::OP_TICK) && !idle_ff;
   // chips beyond the mask width come up disabled
   assign en_bit    = 1'(cfg.enable_mask >> idx);

   chw_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_CHIPS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (cmd.upd),
      .wr_addr (addr),
      .wr_data (new_row),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   // rows never written read as zero
   assign old_row = rd_valid_ff ? chw_pkg::row_type'(ram_q) : '0;

   // signed age must be non-negative and at least the timeout
   assign since     = now_ff - old_row.last_active;
   assign timed_out = stamped_ff[addr] && !since[31] &&
                      (since >= 32'(cfg.timeout_seconds));
   assign too_many  = (old_row.error_run > cfg.error_limit);
   assign hit       = timed_out || too_many;

   always_comb begin
      new_row   = old_row;
      stamp_set = 1'b0;
      case (op_ff)
         chw_pkg::OP_START: begin
            new_row.last_active = now_ff + chw_pkg::START_GRACE;
            stamp_set           = 1'b1;
         end
         chw_pkg::OP_REPORT: begin
            case (outcome_ff)
               chw_pkg::OUTC_VALID: begin
                  new_row.last_active = now_ff;
                  new_row.error_run   = '0;
                  new_row.valid_count = old_row.valid_count + 32'd1;
                  stamp_set           = 1'b1;
               end
               chw_pkg::OUTC_HWERR: begin
                  new_row.last_active = now_ff;
                  if (old_row.error_run != chw_pkg::ERR_RUN_MAX) begin
                     new_row.error_run = old_row.error_run + 16'd1;
                  end
                  stamp_set = 1'b1;
               end
               chw_pkg::OUTC_DUPE: begin
                  new_row.dupe_count = old_row.dupe_count + 32'd1;
               end
               default: begin
                  new_row = old_row;
               end
            endcase
         end
         chw_pkg::OP_TICK: begin
            if (idle_ff) begin
               new_row.error_run = '0;
               if (stamped_ff[addr]) begin
                  new_row.last_active = now_ff + chw_pkg::IDLE_GRACE;
               end
            end else if (hit) begin
               new_row.last_active = now_ff;
               new_row.error_run   = '0;
               stamp_set           = 1'b1;
               if (timed_out) begin
                  new_row.timeout_actions = old_row.timeout_actions + 32'd1;
               end else begin
                  new_row.error_actions = old_row.error_actions + 32'd1;
               end
            end
         end
         default: begin
            new_row = old_row;
         end
      endcase
   end

   // item latch and result payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= in_cmd;
         now_ff     <= in_now;
         chip_ff    <= in_chip;
         outcome_ff <= in_outcome;
         idle_ff    <= in_idle_pool;
         action_ff  <= chw_pkg::ACT_NONE;
         sent_ff    <= 1'b0;
         achip_ff   <= '0;
      end else if (cmd.upd && busy_tick && hit) begin
         action_ff <= timed_out ? chw_pkg::ACT_TIMEOUT : chw_pkg::ACT_ERRORS;
         sent_ff   <= !cfg.log_only;
         achip_ff  <= 4'(idx);
      end
      if (cmd.rd) begin
         rd_valid_ff <= row_valid_ff[addr];
      end
      if (cmd.load_out) begin
         out_action_ff <= action_ff;
         out_sent_ff   <= sent_ff;
         out_achip_ff  <= achip_ff;
         out_total_ff  <= total_ff;
         out_valid_ff  <= chip_ok ? old_row.valid_count : '0;
         out_dupe_ff   <= chip_ok ? old_row.dupe_count : '0;
         out_tout_ff   <= chip_ok ? old_row.timeout_actions : '0;
         out_err_ff    <= chip_ok ? old_row.error_actions : '0;
      end
   end

   // per-chip flags and the action total
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         stamped_ff   <= '0;
         enabled_ff   <= '0;
         total_ff     <= '0;
      end else if (cmd.upd) begin
         row_valid_ff[addr] <= 1'b1;
         if (stamp_set) begin
            stamped_ff[addr] <= 1'b1;
         end
         if (op_ff == chw_pkg::OP_START) begin
            enabled_ff[addr] <= en_bit;
         end
         if (busy_tick && hit) begin
            total_ff <= total_ff + 32'd1;
         end
      end
   end

   assign status.op      = op_ff;
   assign status.idle    = idle_ff;
   assign status.chip_ok = chip_ok;
   assign status.at_end  = (idx >= chips_n);
   assign status.en_here = enabled_ff[AW'(idx)];
   assign status.hit     = hit;

   assign out_action         = out_action_ff;
   assign out_reset_sent     = out_sent_ff;
   assign out_action_chip    = out_achip_ff;
   assign out_total_resets   = out_total_ff;
   assign out_valid_count    = out_valid_ff;
   assign out_dupe_count     = out_dupe_ff;
   assign out_timeout_resets = out_tout_ff;
   assign out_error_resets   = out_err_ff;

endmodule

`default_nettype wire

/* sv/chip_health_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// chip_health_watchdog_unit
// Health monitor for a board of hash chips: start, nonce report and tick items.
// ----------------------------------------------------------------------------
//
//  channel  | direction | beat contents
//  ---------+-----------+--------------------------------------------------
//  req_     | in        | tuser: cmd; tdata: now, chip, outcome, idle_pool
//  rsp_     | out       | tdata: action, flags, chip, totals, chip counters
//  csr_     | in        | register index and write data, always ready
//
//  Each item is handled by a read-modify-write of the row ram through one
//  shared address: a report updates the row of its chip, a start or idle tick
//  every chip in use, a busy tick each enabled chip up to the first hit.
//  A new item is taken whenever the sequencer is idle, even while the last
//  result waits; a stalled result holds the sequencer before its output load.
//  Reset clears the per-chip flags, the action total and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module chip_health_watchdog_unit #(
   parameter int unsigned MAX_CHIPS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: now_seconds[31:0], chip[35:32], outcome[37:36], idle_pool[38]
   input  wire logic [chw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: cmd[1:0]
   input  wire logic [1:0]                      req_tuser,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: action[1:0], reset_sent[2], action_chip[6:3],
   // total_resets[38:7], chip_valid_count[70:39], chip_dupe_count[102:71],
   // chip_timeout_resets[134:103], chip_error_resets[166:135]
   output logic [chw_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [chw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [chw_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned CW = $clog2(MAX_CHIPS + 1);

   chw_pkg::cfg_type       cfg_ff;
   chw_pkg::dp_cmd_type    cmd;
   chw_pkg::dp_status_type status;
   logic [CW-1:0]          idx;

   logic [1:0]  action;
   logic        reset_sent;
   logic [3:0]  action_chip;
   logic [31:0] total_resets;
   logic [31:0] valid_count;
   logic [31:0] dupe_count;
   logic [31:0] timeout_resets;
   logic [31:0] error_resets;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chip_count      <= 5'd16;
         cfg_ff.enable_mask     <= 16'hFFFF;
         cfg_ff.timeout_seconds <= 16'd10;
         cfg_ff.error_limit     <= 16'd10;
         cfg_ff.log_only        <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            chw_pkg::CSR_CHIP_COUNT:  cfg_ff.chip_count      <= csr_data[4:0];
            chw_pkg::CSR_ENABLE_MASK: cfg_ff.enable_mask     <= csr_data;
            chw_pkg::CSR_TIMEOUT:     cfg_ff.timeout_seconds <= csr_data;
            chw_pkg::CSR_ERROR_LIMIT: cfg_ff.error_limit     <= csr_data;
            chw_pkg::CSR_LOG_ONLY:    cfg_ff.log_only        <= csr_data[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   chw_ctrl #(
      .MAX_CHIPS (MAX_CHIPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .idx        (idx)
   );

   chw_dp #(
      .MAX_CHIPS (MAX_CHIPS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_cmd             (req_tuser),
      .in_now             (req_tdata[31:0]),
      .in_chip            (req_tdata[35:32]),
      .in_outcome         (req_tdata[37:36]),
      .in_idle_pool       (req_tdata[38]),
      .cmd                (cmd),
      .idx                (idx),
      .status             (status),
      .out_action         (action),
      .out_reset_sent     (reset_sent),
      .out_action_chip    (action_chip),
      .out_total_resets   (total_resets),
      .out_valid_count    (valid_count),
      .out_dupe_count     (dupe_count),
      .out_timeout_resets (timeout_resets),
      .out_error_resets   (error_resets)
   );

   assign rsp_tdata = {1'b0, error_resets, timeout_resets, dupe_count, valid_count,
                       total_resets, action_chip, reset_sent, action};

   // a taken item leaves the sequencer busy in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer took a second item back to back");

   // no action means no reset and no chip named
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == chw_pkg::ACT_NONE))
         |-> (rsp_tdata[6:2] == 5'd0))
      else $error("reset or chip reported without an action");

   // an action always names a chip that exists
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != chw_pkg::ACT_NONE))
         |-> (32'(rsp_tdata[6:3]) < MAX_CHIPS))
      else $error("action names a chip beyond the board");

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip health watchdog testbench
// Drives start, nonce report and tick beats into the watchdog, keeps its own
// copy of the per-chip state and configuration, and checks every result beat
// field by field. A short stimulus table comes first, then phases of random
// traffic under changing register settings.
// ----------------------------------------------------------------------------

module testbench;
   import chw_pkg::*;

   localparam int unsigned CHIPS = 16;
   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned LONG_HOLD = 300;

   // codes the package leaves unnamed, the block must ignore them
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [1:0] OUTC_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic        sent;
      logic [3:0]  chip;
      logic [31:0] total;
      logic [31:0] valid;
      logic [31:0] dupe;
      logic [31:0] tmo;
      logic [31:0] err;
   } watchdog_rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [31:0]      now;
      logic [3:0]       chip;
      logic [1:0]       outc;
      logic             idle;
      logic             known;
      watchdog_rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic req_tvalid;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   chip_health_watchdog_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog state as the block should hold it
   cfg_type   cfg;
   bit [31:0] act_time [CHIPS];
   bit        act_seen [CHIPS];
   bit [15:0] err_streak [CHIPS];
   bit        chip_on [CHIPS];
   bit [31:0] valid_cnt [CHIPS];
   bit [31:0] dupe_cnt [CHIPS];
   bit [31:0] tmo_cnt [CHIPS];
   bit [31:0] erract_cnt [CHIPS];
   bit [31:0] action_count;

   watchdog_rsp_type rsp_expect_q [$];
   int unsigned pending_rsp = 0;
   int unsigned fail_count = 0;
   int unsigned gap_pct = 25;
   bit long_hold_req = 1'b0;
   stim_row_type drv_row = '0;
   logic [31:0] wall_now = 32'd0;
   stim_row_type directed_rows [14];

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fail_count++;
      $display("mismatch %s: expected %0h, got %0h at %0t ns", what, want, got, $time);
   endtask

   task automatic check_result(input watchdog_rsp_type want, input watchdog_rsp_type got);
      if (got.action !== want.action) report_mismatch("action", want.action, got.action);
      if (got.sent !== want.sent) report_mismatch("reset_sent", want.sent, got.sent);
      if (got.chip !== want.chip) report_mismatch("action_chip", want.chip, got.chip);
      if (got.total !== want.total) report_mismatch("total_resets", want.total, got.total);
      if (got.valid !== want.valid) report_mismatch("chip_valid_count", want.valid, got.valid);
      if (got.dupe !== want.dupe) report_mismatch("chip_dupe_count", want.dupe, got.dupe);
      if (got.tmo !== want.tmo) report_mismatch("chip_timeout_resets", want.tmo, got.tmo);
      if (got.err !== want.err) report_mismatch("chip_error_resets", want.err, got.err);
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      case (idx)
         CSR_CHIP_COUNT:  cfg.chip_count = value[4:0];
         CSR_ENABLE_MASK: cfg.enable_mask = value;
         CSR_TIMEOUT:     cfg.timeout_seconds = value;
         CSR_ERROR_LIMIT: cfg.error_limit = value;
         CSR_LOG_ONLY:    cfg.log_only = value[0];
         default: ;
      endcase
   endtask

   function automatic int unsigned chips_active();
      return (cfg.chip_count > 5'd16) ? CHIPS : int'(cfg.chip_count);
   endfunction

   // one step of the watchdog: updates the state copy, returns the result beat
   function automatic watchdog_rsp_type predict_health(input logic [1:0] op,
                                                       input logic [31:0] now,
                                                       input logic [3:0] chip,
                                                       input logic [1:0] outc,
                                                       input logic idle);
      watchdog_rsp_type r;
      int unsigned n;
      int unsigned i;
      logic [31:0] d;
      logic [1:0] act;
      r = '0;
      act = ACT_NONE;
      n = chips_active();
      case (op)
         OP_START: begin
            for (i = 0; i < n; i++) begin
               chip_on[i] = cfg.enable_mask[i];
               act_time[i] = now + START_GRACE;
               act_seen[i] = 1'b1;
            end
         end
         OP_REPORT: begin
            case (outc)
               OUTC_VALID: begin
                  act_time[chip] = now;
                  act_seen[chip] = 1'b1;
                  err_streak[chip] = '0;
                  valid_cnt[chip]++;
               end
               OUTC_HWERR: begin
                  act_time[chip] = now;
                  act_seen[chip] = 1'b1;
                  if (err_streak[chip] != ERR_RUN_MAX) err_streak[chip]++;
               end
               OUTC_DUPE: dupe_cnt[chip]++;
               default: ;
            endcase
         end
         OP_TICK: begin
            if (idle) begin
               for (i = 0; i < n; i++) begin
                  err_streak[i] = '0;
                  if (act_seen[i]) act_time[i] = now + IDLE_GRACE;
               end
            end else begin
               // first offender in index order wins, timeout before error count
               for (i = 0; i < n && act == ACT_NONE; i++) begin
                  if (chip_on[i]) begin
                     d = now - act_time[i];
                     if (act_seen[i] && !d[31] && d >= {16'd0, cfg.timeout_seconds})
                        act = ACT_TIMEOUT;
                     else if (err_streak[i] > cfg.error_limit)
                        act = ACT_ERRORS;
                     if (act != ACT_NONE) begin
                        r.chip = i[3:0];
                        r.sent = ~cfg.log_only;
                        act_time[i] = now;
                        act_seen[i] = 1'b1;
                        err_streak[i] = '0;
                        if (act == ACT_TIMEOUT) tmo_cnt[i]++;
                        else erract_cnt[i]++;
                        action_count++;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.action = act;
      r.total = action_count;
      r.valid = valid_cnt[chip];
      r.dupe = dupe_cnt[chip];
      r.tmo = tmo_cnt[chip];
      r.err = erract_cnt[chip];
      return r;
   endfunction

   // beats are taken at the rising edge, before the block updates its outputs
   always @(posedge clock) begin
      watchdog_rsp_type want;
      watchdog_rsp_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) begin
            want = predict_health(req_tuser, req_tdata[31:0], req_tdata[35:32],
                                  req_tdata[37:36], req_tdata[38]);
            if (drv_row.known) want = drv_row.want;
            rsp_expect_q.push_back(want);
            pending_rsp++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.action = rsp_tdata[1:0];
            got.sent = rsp_tdata[2];
            got.chip = rsp_tdata[6:3];
            got.total = rsp_tdata[38:7];
            got.valid = rsp_tdata[70:39];
            got.dupe = rsp_tdata[102:71];
            got.tmo = rsp_tdata[134:103];
            got.err = rsp_tdata[166:135];
            if (rsp_expect_q.size() == 0) begin
               report_mismatch("result beat with none pending, total_resets", '0, got.total);
            end else begin
               want = rsp_expect_q.pop_front();
               pending_rsp--;
               check_result(want, got);
            end
         end
      end
   end

   function automatic int unsigned gap_cycles();
      return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   // result side back-pressure
   initial begin
      int unsigned stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            stall_left = gap_cycles() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input stim_row_type row);
      @(negedge clock);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles()) @(negedge clock);
      end
      drv_row = row;
      req_tuser <= row.op;
      req_tdata <= {1'b0, row.idle, row.outc, row.chip, row.now};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic park_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_watchdog(input int unsigned phase);
      logic [15:0] v_count, v_mask, v_tmo, v_lim, v_log;
      case (phase)
         0: {v_count, v_mask, v_tmo, v_lim, v_log} = {16'd16, 16'hFFFF, 16'd0, 16'd0, 16'd0};
         1: {v_count, v_mask, v_tmo, v_lim, v_log} = {16'd1, 16'h0001, 16'hFFFF, 16'hFFFF,
                                                      16'd1};
         2: {v_count, v_mask, v_tmo, v_lim, v_log} = {16'hFFE0, 16'hFFFF, 16'd5, 16'd2, 16'd0};
         3: {v_count, v_mask, v_tmo, v_lim, v_log} = {16'h001F, 16'h0000, 16'd3, 16'd1, 16'd1};
         4: {v_count, v_mask, v_tmo, v_lim, v_log} = {16'hFFF1, 16'hA5A5, 16'd20, 16'd3,
                                                      16'hFFFE};
         5: {v_count, v_mask, v_tmo, v_lim, v_log} = {16'd16, 16'h5A5A, 16'd8, 16'd0, 16'h8001};
         default: begin
            v_count = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 16)) : 16'($urandom());
            v_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
            v_tmo = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 30)) : 16'($urandom());
            v_lim = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 6)) : 16'($urandom());
            v_log = 16'($urandom());
         end
      endcase
      write_reg(CSR_CHIP_COUNT, v_count);
      write_reg(CSR_ENABLE_MASK, v_mask);
      write_reg(CSR_TIMEOUT, v_tmo);
      write_reg(CSR_ERROR_LIMIT, v_lim);
      write_reg(CSR_LOG_ONLY, v_log);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_SPARE_FIRST + 3'($urandom_range(0, 2)), 16'($urandom()));
   endtask

   // mostly creeping time so stamps and timeouts interact, now and then a jump
   function automatic logic [31:0] next_now();
      int unsigned r;
      int unsigned span;
      r = $urandom_range(0, 99);
      span = (cfg.timeout_seconds > 16'd60) ? 64 : int'(cfg.timeout_seconds) + 4;
      if (r < 60) wall_now += $urandom_range(0, 2);
      else if (r < 90) wall_now += $urandom_range(0, span);
      else if (r < 98) wall_now += $urandom_range(0, 1000);
      else wall_now = $urandom();
      return wall_now;
   endfunction

   function automatic stim_row_type random_row(input logic [3:0] focus);
      stim_row_type row;
      int unsigned r;
      int unsigned n;
      row = '0;
      n = chips_active();
      row.now = next_now();
      row.chip = 4'($urandom_range(0, 15));
      row.outc = 2'($urandom_range(0, 3));
      row.idle = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 33) begin
         row.op = OP_TICK;
         row.idle = ($urandom_range(0, 99) < 8);
      end else if (r < 92) begin
         row.op = OP_REPORT;
         r = $urandom_range(0, 99);
         if (r < 30) begin
            // build up an error run on one chip
            row.chip = focus;
            row.outc = ($urandom_range(0, 99) < 85) ? OUTC_HWERR : OUTC_VALID;
         end else begin
            if (n != 0 && $urandom_range(0, 99) < 80) row.chip = 4'($urandom_range(0, n - 1));
            r = $urandom_range(0, 99);
            if (r < 40) row.outc = OUTC_VALID;
            else if (r < 80) row.outc = OUTC_HWERR;
            else if (r < 96) row.outc = OUTC_DUPE;
            else row.outc = OUTC_SPARE;
         end
      end else if (r < 96) begin
         row.op = OP_START;
      end else begin
         row.op = OP_SPARE;
      end
      return row;
   endfunction

   task automatic run_phase(input int unsigned phase, inout int unsigned sent_items);
      int unsigned count;
      int unsigned k;
      logic [3:0] focus;
      stim_row_type row;
      park_req();
      wait (pending_rsp == 0);
      program_watchdog(phase);
      gap_pct = (phase % 4 == 1) ? 0 : 25;
      if ($urandom_range(0, 4) == 0) wall_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
      focus = (chips_active() != 0) ? 4'($urandom_range(0, chips_active() - 1)) : 4'd0;
      count = $urandom_range(60, 120);
      for (k = 0; k < count; k++) begin
         if (k == count / 3 && phase == 6) long_hold_req = 1'b1;
         if (k == count / 2 && phase == 3) begin
            park_req();
            wait (pending_rsp == 0);
         end
         row = random_row(focus);
         if (k == 0 && $urandom_range(0, 99) < 85) row.op = OP_START;
         send_beat(row);
         sent_items++;
      end
   endtask

   initial begin
      int unsigned sent_items;
      int unsigned phase;
      int unsigned k;
      cfg = '{chip_count: 5'd16, enable_mask: 16'hFFFF, timeout_seconds: 16'd10,
              error_limit: 16'd10, log_only: 1'b1};
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = OP_TICK;
      req_tvalid = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CHIP_COUNT;
      csr_data = '0;
      // stamps wrap past zero on start; last rows probe the signed time difference
      directed_rows = '{
         '{OP_TICK, 32'd0, 4'd0, OUTC_VALID, 1'b0, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
         '{OP_REPORT, 32'hFFFF_FFFF, 4'd15, OUTC_VALID, 1'b0, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0}},
         '{OP_REPORT, 32'hFFFF_FFFF, 4'd15, OUTC_DUPE, 1'b1, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0}},
         '{OP_REPORT, 32'd5, 4'd15, OUTC_SPARE, 1'b0, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0}},
         '{OP_SPARE, 32'd7, 4'd15, OUTC_HWERR, 1'b1, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0}},
         '{OP_START, 32'hFFFF_FFF8, 4'd0, OUTC_VALID, 1'b0, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
         '{OP_TICK, 32'd11, 4'd0, OUTC_VALID, 1'b0, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
         '{OP_TICK, 32'd12, 4'd0, OUTC_VALID, 1'b0, 1'b1,
           '{ACT_TIMEOUT, 1'b0, 4'd0, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0}},
         '{OP_TICK, 32'd12, 4'd1, OUTC_VALID, 1'b0, 1'b1,
           '{ACT_TIMEOUT, 1'b0, 4'd1, 32'd2, 32'd0, 32'd0, 32'd1, 32'd0}},
         '{OP_REPORT, 32'd12, 4'd2, OUTC_HWERR, 1'b0, 1'b0, '0},
         '{OP_TICK, 32'd100, 4'd15, OUTC_DUPE, 1'b1, 1'b1,
           '{ACT_NONE, 1'b0, 4'd0, 32'd2, 32'd1, 32'd1, 32'd0, 32'd0}},
         '{OP_TICK, 32'h8000_0078, 4'd0, OUTC_VALID, 1'b0, 1'b0, '0},
         '{OP_TICK, 32'h8000_0077, 4'd0, OUTC_VALID, 1'b0, 1'b0, '0},
         '{OP_REPORT, 32'd0, 4'd0, OUTC_VALID, 1'b0, 1'b0, '0}
      };
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(directed_rows); k++) send_beat(directed_rows[k]);

      sent_items = 0;
      phase = 0;
      while (sent_items < RANDOM_ITEMS) begin
         run_phase(phase, sent_items);
         phase++;
      end

      park_req();
      wait (pending_rsp == 0);
      repeat (64) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
